@@ hw/rtl/sfct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sfct_pkg;

    // Command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Stored base codes: 0 A, 1 C, 2 G, 3 T, 4 other
    typedef logic [2:0] t_code;

    localparam t_code CODE_A     = 3'd0;
    localparam t_code CODE_C     = 3'd1;
    localparam t_code CODE_G     = 3'd2;
    localparam t_code CODE_T     = 3'd3;
    localparam t_code CODE_OTHER = 3'd4;

    localparam logic [7:0] CHAR_X = 8'h58;

    localparam int FRAME_LAST = 5;

    // Standard genetic code, indexed by c0*16 + c1*4 + c2
    localparam logic [8*64-1:0] CODON_LETTERS =
        "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLF";

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  base_char;
        logic [2:0]  frame;
        logic [10:0] codon_index;
    } t_item;

    typedef struct packed {
        logic [7:0]  amino_acid;
        logic        in_range;
        logic [10:0] frame_codons;
        logic [12:0] seq_length;
        logic        store_full;
    } t_result;

    function automatic t_code fold_base(input logic [7:0] ch);
        t_code code;
        case (ch)
            "A", "a": code = CODE_A;
            "C", "c": code = CODE_C;
            "G", "g": code = CODE_G;
            "T", "t": code = CODE_T;
            default:  code = CODE_OTHER;
        endcase
        return code;
    endfunction

    function automatic t_code complement_code(input t_code c);
        t_code res;
        if (c < CODE_OTHER) begin
            res = CODE_T - c;
        end else begin
            res = CODE_OTHER;
        end
        return res;
    endfunction

    function automatic logic [7:0] codon_letter(input logic [5:0] idx);
        logic [8:0] sel;
        sel = {~idx, 3'b000};
        return CODON_LETTERS[sel +: 8];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sfct_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfct_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire sfct_pkg::t_code i_wdata,
    input  wire logic           i_re,
    input  wire logic [AW-1:0]  i_raddr,
    output sfct_pkg::t_code     o_rdata
);
    import sfct_pkg::*;

    t_code r_mem [DEPTH];
    t_code r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/sfct_codon.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfct_codon (
    input  wire sfct_pkg::t_code i_code0,
    input  wire sfct_pkg::t_code i_code1,
    input  wire sfct_pkg::t_code i_code2,
    input  wire logic            i_reverse,
    output logic [7:0]           o_amino
);
    import sfct_pkg::*;

    t_code c0;
    t_code c1;
    t_code c2;

    always_comb begin
        c0 = i_reverse ? complement_code(i_code0) : i_code0;
        c1 = i_reverse ? complement_code(i_code1) : i_code1;
        c2 = i_reverse ? complement_code(i_code2) : i_code2;
        if (c0 < CODE_OTHER && c1 < CODE_OTHER && c2 < CODE_OTHER) begin
            o_amino = codon_letter({c0[1:0], c1[1:0], c2[1:0]});
        end else begin
            o_amino = CHAR_X;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/six_frame_codon_translator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Clear, append and out-of-range query: result strobed in the cycle after accept, busy stays low,
// so these take one beat per cycle.
// In-range query: three reads on the base memory's single read port, result strobed after S_RD0,
// S_RD1, S_RD2 and S_FIN, busy in those states; a new item is taken in the cycle the result shows.
// The receiver cannot stall: o_done is high for exactly one cycle per result.
// Synchronous reset empties the sequence; the base memory itself is not cleared.
module six_frame_codon_translator #(
    parameter int MAX_BASES = 4096
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire sfct_pkg::t_item  i_item,
    output logic                  busy,
    output logic                  o_done,
    output sfct_pkg::t_result     o_result
);
    import sfct_pkg::*;

    localparam int AW = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;
    localparam int LW = $clog2(MAX_BASES + 1);
    localparam int PW = (LW > 13) ? LW : 13;
    localparam int CW = (LW > 11) ? LW : 11;
    localparam int SW = (LW > 13) ? LW : 13;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD0  = 5'b00010,
        S_RD1  = 5'b00100,
        S_RD2  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_q, n_q;
    logic [1:0]      r_r, n_r;
    logic [AW-1:0]   r_pos, n_pos;
    logic            r_reverse, n_reverse;
    t_code           r_code0, n_code0;
    t_code           r_code1, n_code1;
    logic            r_done, n_done;
    t_result         r_result, n_result;

    logic            accept;
    logic [1:0]      off;
    logic            frame_ok;
    logic [LW-1:0]   count;
    logic            idx_in;
    logic [PW-1:0]   fwd_start;
    logic [PW-1:0]   rev_start;
    logic            full;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_code           mem_wdata;
    logic            mem_re;
    t_code           mem_rdata;
    logic [7:0]      amino;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        case (i_item.frame)
            3'd1, 3'd4: off = 2'd1;
            3'd2, 3'd5: off = 2'd2;
            default:    off = 2'd0;
        endcase
        frame_ok = (i_item.frame <= 3'(FRAME_LAST));

        // floor((len - off) / 3) from len = 3q + r
        if (r_r >= off) begin
            count = r_q;
        end else if (r_q == '0) begin
            count = '0;
        end else begin
            count = r_q - LW'(1);
        end

        idx_in    = (CW'(i_item.codon_index) < CW'(count));
        fwd_start = PW'(off) + PW'(i_item.codon_index) + (PW'(i_item.codon_index) << 1);
        rev_start = PW'(r_len) - PW'(1) - fwd_start;
        full      = (r_len >= LW'(MAX_BASES));
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_q       = r_q;
        n_r       = r_r;
        n_pos     = r_pos;
        n_reverse = r_reverse;
        n_code0   = r_code0;
        n_code1   = r_code1;
        n_done    = 1'b0;
        n_result  = r_result;
        mem_we    = 1'b0;
        mem_waddr = r_len[AW-1:0];
        mem_wdata = fold_base(i_item.base_char);
        mem_re    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_result.amino_acid   = '0;
                    n_result.in_range     = 1'b0;
                    n_result.frame_codons = '0;
                    n_result.store_full   = 1'b0;
                    n_done                = 1'b1;
                    case (i_item.cmd)
                        CMD_CLEAR: begin
                            n_len = '0;
                            n_q   = '0;
                            n_r   = 2'd0;
                        end
                        CMD_APPEND: begin
                            if (full) begin
                                n_result.store_full = 1'b1;
                            end else begin
                                mem_we = 1'b1;
                                n_len  = r_len + LW'(1);
                                if (r_r == 2'd2) begin
                                    n_r = 2'd0;
                                    n_q = r_q + LW'(1);
                                end else begin
                                    n_r = r_r + 2'd1;
                                end
                            end
                        end
                        CMD_QUERY: begin
                            if (frame_ok) begin
                                n_result.frame_codons = 11'(count);
                                if (idx_in) begin
                                    // hold the beat until the three bases are read
                                    n_result.in_range = 1'b1;
                                    n_done            = 1'b0;
                                    n_reverse         = (i_item.frame > 3'd2);
                                    n_pos = (i_item.frame > 3'd2) ? rev_start[AW-1:0]
                                                                  : fwd_start[AW-1:0];
                                    n_state           = S_RD0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_result.seq_length = 13'(SW'(n_len));
                end
            end
            S_RD0: begin
                mem_re  = 1'b1;
                n_pos   = r_reverse ? r_pos - AW'(1) : r_pos + AW'(1);
                n_state = S_RD1;
            end
            S_RD1: begin
                mem_re  = 1'b1;
                n_pos   = r_reverse ? r_pos - AW'(1) : r_pos + AW'(1);
                n_code0 = mem_rdata;
                n_state = S_RD2;
            end
            S_RD2: begin
                mem_re  = 1'b1;
                n_code1 = mem_rdata;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_result.amino_acid = amino;
                n_done              = 1'b1;
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_q     <= '0;
            r_r     <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_q     <= n_q;
            r_r     <= n_r;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_reverse <= n_reverse;
        r_code0   <= n_code0;
        r_code1   <= n_code1;
        r_result  <= n_result;
    end

    sfct_store #(
        .DEPTH (MAX_BASES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_pos),
        .o_rdata (mem_rdata)
    );

    sfct_codon u_codon (
        .i_code0   (r_code0),
        .i_code1   (r_code1),
        .i_code2   (mem_rdata),
        .i_reverse (r_reverse),
        .o_amino   (amino)
    );

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ tb/sv/six_frame_codon_translator_test.sv @@
`timescale 1ns / 1ps

module six_frame_codon_translator_test;
    import sfct_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 20;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Amino acid per codon, first codon in the top byte, codon = b0*16 + b1*4 + b2
    localparam logic [8*64-1:0] AMINO_TABLE =
        "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLF";
    localparam logic [8*8-1:0] BASE_CHARS = "ACGTacgt";

    typedef struct packed {
        t_item      item;
        logic [3:0] gap;
    } t_beat_slot;

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    six_frame_codon_translator #(
        .MAX_BASES(STORE_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_item(i_item),
        .busy(busy),
        .o_done(o_done),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Stimulus plan and its shadow length
    t_beat_slot  pending_beats[$];
    int unsigned plan_len = 0;
    bit          idling_on = 1'b1;

    // Translator shadow state
    t_code       bases[STORE_DEPTH];
    int unsigned seq_len = 0;
    t_result     expected_results[$];

    t_beat_slot  staged_beat;
    bit          staged_valid = 1'b0;
    int          gap_left = 0;
    t_result     predicted;

    int beats_accepted = 0;
    int codon_hits = 0;
    int append_drops = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    function automatic t_code fold_char(input logic [7:0] ch);
        logic [7:0] upper;
        t_code      code;
        upper = ch & 8'hDF;
        code = CODE_OTHER;
        if (upper == "A") code = CODE_A;
        if (upper == "C") code = CODE_C;
        if (upper == "G") code = CODE_G;
        if (upper == "T") code = CODE_T;
        return code;
    endfunction

    function automatic t_code flip_code(input t_code c);
        return c[2] ? CODE_OTHER : {1'b0, ~c[1:0]};
    endfunction

    task automatic translate_item(input t_item it, output t_result res);
        int unsigned off;
        int unsigned cnt;
        int unsigned pos;
        t_code       trip[3];
        logic [5:0]  codon;
        res = '0;
        case (it.cmd)
            CMD_CLEAR: begin
                seq_len = 0;
            end
            CMD_APPEND: begin
                if (seq_len >= STORE_DEPTH) begin
                    res.store_full = 1'b1;
                end else begin
                    bases[seq_len] = fold_char(it.base_char);
                    seq_len++;
                end
            end
            CMD_QUERY: begin
                if (it.frame <= FRAME_LAST) begin
                    off = it.frame % 3;
                    cnt = (seq_len > off) ? (seq_len - off) / 3 : 0;
                    res.frame_codons = cnt[10:0];
                    if (it.codon_index < cnt) begin
                        res.in_range = 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            pos = off + 3 * it.codon_index + k;
                            // reverse frames walk the complement from the tail
                            trip[k] = (it.frame < 3) ? bases[pos]
                                                     : flip_code(bases[seq_len - 1 - pos]);
                        end
                        if (trip[0][2] || trip[1][2] || trip[2][2]) begin
                            res.amino_acid = CHAR_X;
                        end else begin
                            codon = {trip[0][1:0], trip[1][1:0], trip[2][1:0]};
                            res.amino_acid = AMINO_TABLE[(63 - codon) * 8 +: 8];
                        end
                    end
                end
            end
            default: ;
        endcase
        res.seq_length = seq_len[12:0];
    endtask

    task automatic push_beat(input logic [1:0] cmd, input logic [7:0] ch,
                             input logic [2:0] fr, input logic [10:0] idx);
        t_beat_slot b;
        b.item.cmd = cmd;
        b.item.base_char = ch;
        b.item.frame = fr;
        b.item.codon_index = idx;
        b.gap = (idling_on && $urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
        pending_beats.insert(pending_beats.size(), b);
        if (cmd == CMD_CLEAR) begin
            plan_len = 0;
        end else if (cmd == CMD_APPEND && plan_len < STORE_DEPTH) begin
            plan_len++;
        end
    endtask

    function automatic logic [7:0] rand_base();
        logic [7:0] ch;
        if ($urandom_range(0, 11) < 10) begin
            ch = BASE_CHARS[8 * $urandom_range(0, 7) +: 8];
        end else begin
            ch = 8'($urandom_range(0, 255));
        end
        return ch;
    endfunction

    function automatic int unsigned plan_codons(input int fr);
        int unsigned off;
        off = fr % 3;
        return (plan_len > off) ? (plan_len - off) / 3 : 0;
    endfunction

    task automatic push_query(input int fr, input int unsigned idx);
        push_beat(CMD_QUERY, 8'($urandom_range(0, 255)), fr[2:0], idx[10:0]);
    endtask

    // Driver: one beat per accept, start held until busy drops
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            staged_valid = 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                translate_item(i_item, predicted);
                expected_results.insert(expected_results.size(), predicted);
                beats_accepted++;
                if (predicted.in_range) codon_hits++;
                if (predicted.store_full) append_drops++;
            end
            if (!(start && busy)) begin
                if (!staged_valid && pending_beats.size() != 0) begin
                    staged_beat = pending_beats.pop_front();
                    staged_valid = 1'b1;
                    gap_left = int'(staged_beat.gap);
                end
                if (staged_valid && gap_left == 0) begin
                    start <= 1'b1;
                    i_item <= staged_beat.item;
                    staged_valid = 1'b0;
                end else begin
                    start <= 1'b0;
                    if (staged_valid) gap_left--;
                end
            end
        end
    end

    // Monitor: every strobe is one result beat
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: aa=%h inr=%b codons=%0d len=%0d full=%b",
                             o_result.amino_acid, o_result.in_range, o_result.frame_codons,
                             o_result.seq_length, o_result.store_full);
                end
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_result.amino_acid !== want.amino_acid
                        || o_result.in_range !== want.in_range
                        || o_result.frame_codons !== want.frame_codons
                        || o_result.seq_length !== want.seq_length
                        || o_result.store_full !== want.store_full) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch %0d: want aa=%h inr=%b codons=%0d len=%0d full=%b",
                                 results_checked, want.amino_acid, want.in_range,
                                 want.frame_codons, want.seq_length, want.store_full);
                        $display("    got aa=%h inr=%b codons=%0d len=%0d full=%b",
                                 o_result.amino_acid, o_result.in_range, o_result.frame_codons,
                                 o_result.seq_length, o_result.store_full);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int          random_beats;
        int          n;
        int          fr;
        int unsigned cnt;
        bit          fill_done;

        random_beats = 0;
        fill_done = 1'b0;

        // Directed: empty store, start and stop codons, odd bases, both strands
        push_query(0, 0);
        push_beat(CMD_CLEAR, 8'h00, 3'd0, 11'd0);
        push_beat(CMD_APPEND, "a", 3'd0, 11'd0);
        push_beat(CMD_APPEND, "T", 3'd0, 11'd0);
        push_beat(CMD_APPEND, "g", 3'd0, 11'd0);
        push_query(0, 0);
        push_beat(CMD_APPEND, "T", 3'd7, 11'h7FF);
        push_beat(CMD_APPEND, "A", 3'd0, 11'd0);
        push_beat(CMD_APPEND, "a", 3'd0, 11'd0);
        push_beat(CMD_APPEND, "N", 3'd0, 11'd0);
        push_query(0, 1);
        push_query(0, 2);
        push_query(1, 0);
        push_query(2, 1);
        push_query(3, 0);
        push_query(4, 0);
        push_query(5, 0);
        push_query(6, 0);
        push_query(7, 0);
        push_beat(CMD_UNUSED, 8'hFF, 3'd7, 11'h7FF);
        push_beat(CMD_APPEND, 8'hFF, 3'd0, 11'd0);
        push_beat(CMD_APPEND, 8'h00, 3'd0, 11'd0);
        push_query(3, 11'h7FF);
        push_query(5, 1);

        while (random_beats < 800) begin
            idling_on = (random_beats < 700) && ($urandom_range(0, 3) != 0);
            if (!fill_done && random_beats > 350) begin
                // Fill the store to the brim, overflow it, then read the far codons
                fill_done = 1'b1;
                push_beat(CMD_CLEAR, 8'($urandom_range(0, 255)), 3'd0, 11'd0);
                repeat (STORE_DEPTH + 3) begin
                    push_beat(CMD_APPEND, rand_base(), 3'($urandom_range(0, 7)),
                              11'($urandom_range(0, 2047)));
                end
                for (int f = 0; f <= FRAME_LAST; f++) begin
                    cnt = plan_codons(f);
                    push_query(f, cnt - 1);
                    push_query(f, cnt);
                    push_query(f, 0);
                    push_query(f, $urandom_range(1024, cnt - 1));
                    push_query(f, 2047);
                end
            end else if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 4) != 0) begin
                    push_beat(CMD_CLEAR, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                              11'($urandom_range(0, 2047)));
                    random_beats++;
                end
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                 : $urandom_range(0, 30);
                repeat (n) begin
                    push_beat(CMD_APPEND, rand_base(), 3'($urandom_range(0, 7)),
                              11'($urandom_range(0, 2047)));
                end
                random_beats += n;
                n = $urandom_range(3, 15);
                repeat (n) begin
                    fr = $urandom_range(0, FRAME_LAST);
                    cnt = plan_codons(fr);
                    if ($urandom_range(0, 7) == 0) begin
                        push_query(fr, $urandom_range(0, 2047));
                    end else begin
                        push_query(fr, $urandom_range(0, cnt + 1));
                    end
                end
                random_beats += n;
            end else begin
                n = $urandom_range(2, 10);
                repeat (n) begin
                    push_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              3'($urandom_range(0, 7)), 11'($urandom_range(0, 2047)));
                end
                random_beats += n;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || staged_valid || start
               || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d beats of clear, append and six-frame queries, %0d results checked,",
                 beats_accepted, results_checked);
        $display("%0d codons translated in range, %0d appends dropped on a full store",
                 codon_hits, append_drops);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sfct_pkg.sv
hw/rtl/sfct_store.sv
hw/rtl/sfct_codon.sv
hw/rtl/six_frame_codon_translator.sv
tb/sv/six_frame_codon_translator_test.sv
